// File: rtl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
`default_nettype none
package bpa_pkg;
   localparam int NUM_POOLS      = 4;
   localparam int PAGES_PER_POOL = 256;
   localparam int PAGE_BYTES     = 4096;
   localparam int ADDR_W         = 32;
   localparam int SIZE_W         = 32;
   localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
   localparam int BASE_W         = ADDR_W - PAGE_SHIFT;
   localparam int NPAGES_W       = SIZE_W - PAGE_SHIFT + 1;
   localparam int POOL_W         = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int PAGE_W         = $clog2(PAGES_PER_POOL);
   localparam int RUN_W          = PAGE_W + 1;
   localparam int WORD_BITS      = 8;
   localparam int BIT_W          = $clog2(WORD_BITS);
   localparam int WORDS_PER_POOL = PAGES_PER_POOL / WORD_BITS;
   localparam int WIDX_W         = $clog2(WORDS_PER_POOL);
   localparam int MEM_DEPTH      = NUM_POOLS * WORDS_PER_POOL;
   localparam int MEM_AW         = $clog2(MEM_DEPTH);
   localparam int CSR_AW         = 3;
   localparam int CSR_DW         = 32;
   localparam int BASE_RESET     = 512;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_BAD_SIZE = 2'd1,
      STATUS_NO_ROOM  = 2'd2,
      STATUS_BAD_ADDR = 2'd3
   } status_type;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DECODE,
      FSM_SCAN,
      FSM_MODIFY,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      logic              mode;
      logic [SIZE_W-1:0] size_bytes;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] granted_address;
      status_type        status;
   } rsp_type;

   typedef struct packed {
      logic [RUN_W-1:0] run;
      logic [RUN_W-1:0] best;
      logic             hit;
      logic [BIT_W-1:0] hit_pos;
   } scan_type;
endpackage
`default_nettype wire

// File: rtl/bpa_occ_mem.sv
// Occupancy bitmap memory, one byte of page bits per entry, valid bit per entry.
`default_nettype none
module bpa_occ_mem
   import bpa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 we,
   input  wire logic [MEM_AW-1:0]    waddr,
   input  wire logic [WORD_BITS-1:0] wdata,
   input  wire logic                 re,
   input  wire logic [MEM_AW-1:0]    raddr,
   output logic      [WORD_BITS-1:0] rdata
);
   logic [WORD_BITS-1:0] mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] valid_ff;
   logic [WORD_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (we) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= valid_ff[raddr] ? mem[raddr] : '0;
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// File: rtl/bpa_byte_scan.sv
// Free-run tracker over one byte of page bits.
`default_nettype none
module bpa_byte_scan
   import bpa_pkg::*;
(
   input  wire logic [WORD_BITS-1:0] bits,
   input  wire logic [RUN_W-1:0]     run_in,
   input  wire logic [RUN_W-1:0]     best_in,
   input  wire logic [RUN_W-1:0]     pages,
   output scan_type                  result
);
   always_comb begin
      logic [RUN_W-1:0] run;
      logic [RUN_W-1:0] best;
      logic             hit;
      logic [BIT_W-1:0] pos;
      run  = run_in;
      best = best_in;
      hit  = 1'b0;
      pos  = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         run = bits[b] ? '0 : run + RUN_W'(1);
         if (run > best) best = run;
         if (!hit && run == pages) begin
            hit = 1'b1;
            pos = BIT_W'(b);
         end
      end
      result.run     = run;
      result.best    = best;
      result.hit     = hit;
      result.hit_pos = pos;
   end
endmodule
`default_nettype wire

// File: rtl/bitmap_page_allocator.sv
// Top level of the first-fit bitmap page allocator.
// Requests arrive on req_ (valid/stall); one result per request leaves on rsp_.
// A request is taken when req_valid is high and req_stall low; req_stall is
// high while a request is in work. mode 0 allocates size_bytes rounded up to
// 4K pages, mode 1 frees the pages at free_address.
// A rejected request answers without a pass over the bitmap. A free takes one
// pass over the pool's bitmap (32 byte reads). An allocate takes a first-fit
// pass and a mark-and-rescan pass. The bitmap memory's single read port, one
// byte per cycle, bounds these passes.
// The result sits in an output register; while it is stalled the next request
// is taken and worked, and only its delivery waits.
// Reset frees every page, sets each pool's longest run to 256 and the base
// page register to 512. region_base_page sits at APB byte address 0.
`default_nettype none
module bitmap_page_allocator
   import bpa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready
);
   fsm_type               state_ff, state_in;
   logic [BASE_W-1:0]     base_ff;
   logic                  mode_ff;
   logic [NPAGES_W-1:0]   pages_ff;
   logic [BASE_W-1:0]     fpage_ff;
   logic                  badaddr_ff;
   logic [POOL_W-1:0]     pool_ff, pool_in;
   logic [WIDX_W:0]       cnt_ff, cnt_in;
   logic                  pend_ff;
   logic [WIDX_W-1:0]     ridx_ff;
   logic [RUN_W-1:0]      run_ff, run_in;
   logic [RUN_W-1:0]      best_ff, best_in;
   logic                  found_ff, found_in;
   logic [PAGE_W-1:0]     end_ff, end_in;
   logic [PAGE_W-1:0]     lo_ff, lo_in;
   logic [PAGE_W-1:0]     hi_ff, hi_in;
   logic [RUN_W-1:0]      lfr_ff [NUM_POOLS];
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;
   rsp_type               res_ff, res_in;
   logic                  rsp_load;
   logic                  lfr_we;

   logic                  accept;
   logic                  rd_en;
   logic [WORD_BITS-1:0]  rdata;
   logic [WORD_BITS-1:0]  wbyte;
   logic                  we;
   scan_type              scan;
   logic [RUN_W-1:0]      pages_small;
   logic [RUN_W-1:0]      scan_pages;
   logic [BASE_W:0]       diff;
   logic [NPAGES_W:0]     hi_sum;
   logic [BASE_W:0]       gpage;
   logic                  pool_ok;
   logic [POOL_W-1:0]     pool_sel;
   logic                  last;

   assign pready = 1'b1;
   assign prdata = paddr[CSR_AW-1] ? '0 : CSR_DW'(base_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_W'(BASE_RESET);
      end else if (psel && penable && pwrite && !paddr[CSR_AW-1]) begin
         base_ff <= pwdata[BASE_W-1:0];
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != FSM_IDLE);
   assign rd_en     = (state_ff == FSM_SCAN || state_ff == FSM_MODIFY) && !cnt_ff[WIDX_W];
   assign last      = pend_ff && (ridx_ff == WIDX_W'(WORDS_PER_POOL - 1));

   bpa_occ_mem u_mem (
      .clock (clock),
      .reset (reset),
      .we    (we),
      .waddr ({pool_ff, ridx_ff}),
      .wdata (wbyte),
      .re    (rd_en),
      .raddr ({pool_ff, cnt_ff[WIDX_W-1:0]}),
      .rdata (rdata)
   );

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         logic [PAGE_W-1:0] pg;
         pg = {ridx_ff, BIT_W'(b)};
         wbyte[b] = (pg >= lo_ff && pg <= hi_ff) ? !mode_ff : rdata[b];
      end
   end

   assign pages_small = pages_ff[RUN_W-1:0];
   assign scan_pages  = (state_ff == FSM_SCAN) ? pages_small : '0;

   bpa_byte_scan u_scan (
      .bits    ((state_ff == FSM_SCAN) ? rdata : wbyte),
      .run_in  (run_ff),
      .best_in (best_ff),
      .pages   (scan_pages),
      .result  (scan)
   );

   always_comb begin
      pool_ok  = 1'b0;
      pool_sel = '0;
      for (int p = NUM_POOLS - 1; p >= 0; p--) begin
         if (NPAGES_W'(lfr_ff[p]) >= pages_ff) begin
            pool_ok  = 1'b1;
            pool_sel = POOL_W'(p);
         end
      end
   end

   assign diff    = {1'b0, fpage_ff} - {1'b0, base_ff};
   assign hi_sum  = (NPAGES_W + 1)'(diff[PAGE_W-1:0]) + {1'b0, pages_ff}
                    - (NPAGES_W + 1)'(1);
   assign gpage   = {1'b0, base_ff} + (BASE_W + 1)'({pool_ff, lo_ff});

   always_comb begin
      state_in = state_ff;
      pool_in  = pool_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      best_in  = best_ff;
      found_in = found_ff;
      end_in   = end_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      res_in   = res_ff;
      rsp_load = 1'b0;
      we       = 1'b0;
      lfr_we   = 1'b0;
      if (rd_en) cnt_in = cnt_ff + (WIDX_W + 1)'(1);
      case (state_ff)
         FSM_IDLE: begin
            if (accept) state_in = FSM_DECODE;
         end
         FSM_DECODE: begin
            res_in.granted_address = '0;
            cnt_in  = '0;
            run_in  = '0;
            best_in = '0;
            found_in = 1'b0;
            state_in = FSM_FINISH;
            if (pages_ff == '0) begin
               res_in.status = STATUS_BAD_SIZE;
            end else if (mode_ff == MODE_ALLOC) begin
               if (pages_ff > NPAGES_W'(PAGES_PER_POOL)) begin
                  res_in.status = STATUS_BAD_SIZE;
               end else if (!pool_ok) begin
                  res_in.status = STATUS_NO_ROOM;
               end else begin
                  pool_in  = pool_sel;
                  state_in = FSM_SCAN;
               end
            end else if (badaddr_ff || diff[BASE_W]
                         || diff >= (BASE_W + 1)'(NUM_POOLS * PAGES_PER_POOL)) begin
               res_in.status = STATUS_BAD_ADDR;
            end else begin
               pool_in  = diff[POOL_W+PAGE_W-1:PAGE_W];
               lo_in    = diff[PAGE_W-1:0];
               hi_in    = (hi_sum > (NPAGES_W + 1)'(PAGES_PER_POOL - 1))
                          ? PAGE_W'(PAGES_PER_POOL - 1) : hi_sum[PAGE_W-1:0];
               state_in = FSM_MODIFY;
            end
         end
         FSM_SCAN: begin
            if (pend_ff) begin
               run_in = scan.run;
               if (!found_ff && scan.hit) begin
                  found_in = 1'b1;
                  end_in   = {ridx_ff, scan.hit_pos};
               end
            end
            if (last) begin
               cnt_in  = '0;
               run_in  = '0;
               best_in = '0;
               if (found_in) begin
                  hi_in    = end_in;
                  lo_in    = end_in + PAGE_W'(1) - pages_small[PAGE_W-1:0];
                  state_in = FSM_MODIFY;
               end else begin
                  res_in.granted_address = '0;
                  res_in.status = STATUS_NO_ROOM;
                  state_in = FSM_FINISH;
               end
            end
         end
         FSM_MODIFY: begin
            if (pend_ff) begin
               we      = 1'b1;
               run_in  = scan.run;
               best_in = scan.best;
            end
            if (last) begin
               lfr_we        = 1'b1;
               res_in.status = STATUS_DONE;
               res_in.granted_address = (mode_ff == MODE_ALLOC)
                  ? {gpage[BASE_W-1:0], PAGE_SHIFT'(0)} : '0;
               state_in = FSM_FINISH;
            end
         end
         FSM_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < NUM_POOLS; p++) lfr_ff[p] <= RUN_W'(PAGES_PER_POOL);
      end else begin
         state_ff <= state_in;
         pend_ff  <= rd_en;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (lfr_we) lfr_ff[pool_ff] <= scan.best;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_data.mode;
         pages_ff   <= NPAGES_W'(req_data.size_bytes[SIZE_W-1:PAGE_SHIFT])
                       + NPAGES_W'(|req_data.size_bytes[PAGE_SHIFT-1:0]);
         fpage_ff   <= req_data.free_address[ADDR_W-1:PAGE_SHIFT];
         badaddr_ff <= (req_data.free_address == '0)
                       || (|req_data.free_address[PAGE_SHIFT-1:0]);
      end
      ridx_ff  <= cnt_ff[WIDX_W-1:0];
      pool_ff  <= pool_in;
      cnt_ff   <= cnt_in;
      run_ff   <= run_in;
      best_ff  <= best_in;
      found_ff <= found_in;
      end_ff   <= end_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      res_ff   <= res_in;
      if (rsp_load) rsp_ff <= res_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

// File: rtl/bpa_checker.sv
// Port-level assertions for the allocator, bound to the top level.
`default_nettype none
module bpa_checker
   import bpa_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.granted_address[PAGE_SHIFT-1:0] == '0)
      else $error("granted address not page aligned");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_DONE |-> rsp_data.granted_address == '0)
      else $error("failed request carries an address");
endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
